[src/grdc_pkg.sv]
// shared widths, constants and codes of the grid ray caster
package grdc_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int ONE = 1 << FRAC_BITS;

    // default map side, limited to at most 64 by the 6-bit cell fields
    localparam int MAP_SIDE_DEF = 64;
    localparam int SCREEN_HEIGHT = 512;
    localparam int HALF_HEIGHT = SCREEN_HEIGHT / 2;

    // port widths
    localparam int POS_W = 22;
    localparam int DIR_W = 19;
    localparam int SW_W = 13;
    localparam int CFG_W = 22;
    localparam int CFG_IDX_W = 3;
    localparam int COL_W = 12;
    localparam int CELL_W = 6;
    localparam int DIST_W = 31;
    localparam int HEIGHT_W = 16;
    localparam int DRAW_W = 9;
    localparam int WFRAC_W = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

    // internal widths
    localparam int CAM_W = 32;
    localparam int RD_W = 36;
    localparam int SD_W = 41;
    localparam int MC_W = 8;

    // divider: 33-bit dividend, 41-bit divisor
    localparam int DIV_NW = 33;
    localparam int DIV_DW = SD_W;

    // multiplier: signed 37 x signed 42, three 14-bit digits of b
    localparam int MUL_AW = 37;
    localparam int MUL_BW = 42;
    localparam int MUL_DG = 14;
    localparam int MUL_ND = MUL_BW / MUL_DG;
    localparam int MUL_PW = 80;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 3'd6;

    // operation codes
    localparam logic OP_MAP_WRITE = 1'b0;
    localparam logic OP_CAST = 1'b1;

endpackage

[src/grid_ray_dda_caster.sv]
// top level of the grid ray caster: wall map, sequencer and dda walk
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+---------------------------------------
//  in      | input     | in_valid / in_stall   | op, cell_row, cell_col, cell_is_wall,
//          |           |                       | column
//  out     | output    | out_valid / out_stall | hit_side .. column_echo, one per cast
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// a map write reads the row at accept, then writes it back through the map ram port
// a cast runs up to four divisions on the shared radix-2 divider and five passes
//   on the shared digit multiplier; each dda step is a step, then a map row read
// after reset the map is swept to open, one row per cycle over all MAP_SIDE rows;
//   in_stall stays high meanwhile, config writes are taken as always
// one word is worked on at a time; a finished result sits in the output
//   register, so the next word is taken while out_stall holds it
module grid_ray_dda_caster #(
    parameter int MAP_SIDE = grdc_pkg::MAP_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [grdc_pkg::CELL_W-1:0]         cell_row,
    input  logic [grdc_pkg::CELL_W-1:0]         cell_col,
    input  logic                                cell_is_wall,
    input  logic [grdc_pkg::COL_W-1:0]          column,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit_side,
    output logic [grdc_pkg::CELL_W-1:0]         hit_cell_x,
    output logic [grdc_pkg::CELL_W-1:0]         hit_cell_y,
    output logic [grdc_pkg::DIST_W-1:0]         perp_distance,
    output logic [grdc_pkg::HEIGHT_W-1:0]       slice_height,
    output logic [grdc_pkg::DRAW_W-1:0]         row_first,
    output logic [grdc_pkg::DRAW_W-1:0]         row_last,
    output logic [grdc_pkg::WFRAC_W-1:0]        wall_fraction,
    output logic                                left_map,
    output logic [grdc_pkg::COL_W-1:0]          column_echo,
    // config port
    input  logic                                cfg_we,
    input  logic [grdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grdc_pkg::CFG_W-1:0]          cfg_data
);
    import grdc_pkg::*;

    localparam int AW = $clog2(MAP_SIDE);
    localparam int STEP_LIM = 4 * MAP_SIDE + 4;
    localparam int STEP_W = $clog2(STEP_LIM + 1);

    // sequencer states
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_MW_WR = 4'd2;
    localparam logic [3:0] ST_CAM = 4'd3;
    localparam logic [3:0] ST_RDX = 4'd4;
    localparam logic [3:0] ST_RDY = 4'd5;
    localparam logic [3:0] ST_DX = 4'd6;
    localparam logic [3:0] ST_DY = 4'd7;
    localparam logic [3:0] ST_SX = 4'd8;
    localparam logic [3:0] ST_SY = 4'd9;
    localparam logic [3:0] ST_STEP = 4'd10;
    localparam logic [3:0] ST_TEST = 4'd11;
    localparam logic [3:0] ST_PERP = 4'd12;
    localparam logic [3:0] ST_LH = 4'd13;
    localparam logic [3:0] ST_FRAC = 4'd14;
    localparam logic [3:0] ST_DONE = 4'd15;

    // config registers
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [SW_W-1:0]         width_reg;

    // control
    logic [3:0]    state_reg, state_next;
    logic          issued_reg, issued_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;

    // per-word working registers
    logic [COL_W-1:0]        column_reg, column_next;
    logic [AW-1:0]           wr_row_reg, wr_row_next;
    logic [AW-1:0]           wr_col_reg, wr_col_next;
    logic                    wr_wall_reg, wr_wall_next;
    logic signed [CAM_W-1:0] cam_reg, cam_next;
    logic signed [RD_W-1:0]  rdx_reg, rdx_next, rdy_reg, rdy_next;
    logic [DIST_W-1:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic [SD_W-1:0]         sx_reg, sx_next, sy_reg, sy_next;
    logic signed [MC_W-1:0]  mx_reg, mx_next, my_reg, my_next;
    logic                    side_reg, side_next;
    logic                    left_reg, left_next;
    logic [STEP_W-1:0]       n_reg, n_next;
    logic [SD_W-1:0]         perp_reg, perp_next;
    logic [HEIGHT_W-1:0]     lh_reg, lh_next;
    logic [WFRAC_W-1:0]      frac_reg, frac_next;

    // result register
    logic                  o_side_reg;
    logic [CELL_W-1:0]     o_cx_reg, o_cy_reg;
    logic [DIST_W-1:0]     o_perp_reg;
    logic [HEIGHT_W-1:0]   o_lh_reg;
    logic [DRAW_W-1:0]     o_start_reg, o_end_reg;
    logic [WFRAC_W-1:0]    o_frac_reg;
    logic                  o_left_reg;
    logic [COL_W-1:0]      o_col_reg;
    logic                  o_load;

    // map ram
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [MAP_SIDE-1:0] ram_wdata, ram_rdata;

    // arithmetic units
    logic                     div_start, div_done, mul_start, mul_done;
    logic [DIV_NW-1:0]        div_num, div_q;
    logic [DIV_DW-1:0]        div_den;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;

    // helpers
    logic                   in_acc;
    logic [SW_W-1:0]        width_eff;
    logic [RD_W-1:0]        abs_rdx, abs_rdy;
    logic [FRAC_BITS:0]     fsel_x, fsel_y;
    logic signed [RD_W-1:0] rd_hit;
    logic                   step_x;
    logic signed [MC_W-1:0] mx_step, my_step;
    logic                   off_map;
    logic [HEIGHT_W-2:0]    half_lh;
    logic [HEIGHT_W:0]      end_sum;
    logic [DRAW_W-1:0]      start_val, end_val;

    grdc_ram #(
        .WIDTH(MAP_SIDE),
        .DEPTH(MAP_SIDE)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    grdc_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_q)
    );

    grdc_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_start),
        .a    (mul_a),
        .b    (mul_b),
        .done (mul_done),
        .prod (mul_p)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;

    // operand selection for the shared units
    always_comb
    begin
        width_eff = (width_reg == '0) ? SW_W'(1) : width_reg;
        abs_rdx = rdx_reg[RD_W-1] ? RD_W'(-rdx_reg) : RD_W'(rdx_reg);
        abs_rdy = rdy_reg[RD_W-1] ? RD_W'(-rdy_reg) : RD_W'(rdy_reg);
        // distance to the cell edge the ray heads toward
        fsel_x = rdx_reg[RD_W-1] ? {1'b0, pos_x_reg[FRAC_BITS-1:0]}
                                 : (FRAC_BITS+1)'(ONE) - {1'b0, pos_x_reg[FRAC_BITS-1:0]};
        fsel_y = rdy_reg[RD_W-1] ? {1'b0, pos_y_reg[FRAC_BITS-1:0]}
                                 : (FRAC_BITS+1)'(ONE) - {1'b0, pos_y_reg[FRAC_BITS-1:0]};
        rd_hit = side_reg ? rdx_reg : rdy_reg;

        div_num = '0;
        div_den = '0;
        case (state_reg)
            ST_CAM:
            begin
                div_num = {{(DIV_NW-COL_W-FRAC_BITS-1){1'b0}}, column_reg,
                           {(FRAC_BITS+1){1'b0}}};
                div_den = {{(DIV_DW-SW_W){1'b0}}, width_eff};
            end
            ST_DX:
            begin
                div_num = DIV_NW'(1) << (2 * FRAC_BITS);
                div_den = {{(DIV_DW-RD_W){1'b0}}, abs_rdx};
            end
            ST_DY:
            begin
                div_num = DIV_NW'(1) << (2 * FRAC_BITS);
                div_den = {{(DIV_DW-RD_W){1'b0}}, abs_rdy};
            end
            ST_LH:
            begin
                div_num = DIV_NW'(SCREEN_HEIGHT) << FRAC_BITS;
                div_den = perp_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RDX:
            begin
                mul_a = {{(MUL_AW-DIR_W){plane_x_reg[DIR_W-1]}}, plane_x_reg};
                mul_b = {{(MUL_BW-CAM_W){cam_reg[CAM_W-1]}}, cam_reg};
            end
            ST_RDY:
            begin
                mul_a = {{(MUL_AW-DIR_W){plane_y_reg[DIR_W-1]}}, plane_y_reg};
                mul_b = {{(MUL_BW-CAM_W){cam_reg[CAM_W-1]}}, cam_reg};
            end
            ST_SX:
            begin
                mul_a = {{(MUL_AW-FRAC_BITS-1){1'b0}}, fsel_x};
                mul_b = {{(MUL_BW-DIST_W){1'b0}}, dx_reg};
            end
            ST_SY:
            begin
                mul_a = {{(MUL_AW-FRAC_BITS-1){1'b0}}, fsel_y};
                mul_b = {{(MUL_BW-DIST_W){1'b0}}, dy_reg};
            end
            ST_FRAC:
            begin
                mul_a = {{(MUL_AW-RD_W){rd_hit[RD_W-1]}}, rd_hit};
                mul_b = {{(MUL_BW-SD_W){1'b0}}, perp_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one dda step: the smaller side distance advances, ties go to y
    always_comb
    begin
        step_x = sx_reg < sy_reg;
        mx_step = mx_reg;
        my_step = my_reg;
        if (step_x)
        begin
            mx_step = rdx_reg[RD_W-1] ? mx_reg - 2'sd1 : mx_reg + 2'sd1;
        end
        else
        begin
            my_step = rdy_reg[RD_W-1] ? my_reg - 2'sd1 : my_reg + 2'sd1;
        end
        off_map = (mx_step < 0) || (mx_step >= $signed(MC_W'(MAP_SIDE)))
               || (my_step < 0) || (my_step >= $signed(MC_W'(MAP_SIDE)))
               || (n_reg >= STEP_W'(STEP_LIM));
    end

    // draw rows from the slice height
    always_comb
    begin
        half_lh = lh_reg[HEIGHT_W-1:1];
        if (half_lh > (HEIGHT_W-1)'(HALF_HEIGHT))
        begin
            start_val = '0;
        end
        else
        begin
            start_val = DRAW_W'((HEIGHT_W-1)'(HALF_HEIGHT) - half_lh);
        end
        end_sum = (HEIGHT_W+1)'(HALF_HEIGHT) + {2'b0, half_lh};
        if (end_sum >= (HEIGHT_W+1)'(SCREEN_HEIGHT))
        begin
            end_val = DRAW_W'(SCREEN_HEIGHT - 1);
        end
        else
        begin
            end_val = end_sum[DRAW_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        issued_next = issued_reg;
        clr_next = clr_reg;
        column_next = column_reg;
        wr_row_next = wr_row_reg;
        wr_col_next = wr_col_reg;
        wr_wall_next = wr_wall_reg;
        cam_next = cam_reg;
        rdx_next = rdx_reg;
        rdy_next = rdy_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        mx_next = mx_reg;
        my_next = my_reg;
        side_next = side_reg;
        left_next = left_reg;
        n_next = n_reg;
        perp_next = perp_reg;
        lh_next = lh_reg;
        frac_next = frac_reg;
        o_load = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MAP_SIDE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = cell_row[AW-1:0];
                if (in_acc)
                begin
                    wr_row_next = cell_row[AW-1:0];
                    wr_col_next = cell_col[AW-1:0];
                    wr_wall_next = cell_is_wall;
                    column_next = column;
                    issued_next = 1'b0;
                    if (op == OP_CAST)
                    begin
                        state_next = ST_CAM;
                    end
                    else if ((CELL_W+1)'(cell_row) < (CELL_W+1)'(MAP_SIDE)
                          && (CELL_W+1)'(cell_col) < (CELL_W+1)'(MAP_SIDE))
                    begin
                        state_next = ST_MW_WR;
                    end
                end
            end
            ST_MW_WR:
            begin
                // row read at accept is here now: patch one bit, write back
                ram_we = 1'b1;
                ram_waddr = wr_row_reg;
                ram_wdata = ram_rdata;
                ram_wdata[wr_col_reg] = wr_wall_reg;
                state_next = ST_IDLE;
            end
            ST_CAM, ST_DX, ST_DY, ST_LH:
            begin
                if (!issued_reg)
                begin
                    div_start = 1'b1;
                    issued_next = 1'b1;
                end
                else if (div_done)
                begin
                    issued_next = 1'b0;
                    case (state_reg)
                        ST_CAM:
                        begin
                            cam_next = $signed({1'b0, div_q[CAM_W-2:0]}) - CAM_W'(ONE);
                            state_next = ST_RDX;
                        end
                        ST_DX:
                        begin
                            if (rdx_reg == '0 || div_q > DIV_NW'(DIST_MAX))
                            begin
                                dx_next = DIST_MAX;
                            end
                            else
                            begin
                                dx_next = div_q[DIST_W-1:0];
                            end
                            state_next = ST_DY;
                        end
                        ST_DY:
                        begin
                            if (rdy_reg == '0 || div_q > DIV_NW'(DIST_MAX))
                            begin
                                dy_next = DIST_MAX;
                            end
                            else
                            begin
                                dy_next = div_q[DIST_W-1:0];
                            end
                            state_next = ST_SX;
                        end
                        default:
                        begin
                            if (div_q > DIV_NW'(HEIGHT_MAX))
                            begin
                                lh_next = HEIGHT_MAX;
                            end
                            else
                            begin
                                lh_next = div_q[HEIGHT_W-1:0];
                            end
                            state_next = ST_FRAC;
                        end
                    endcase
                end
            end
            ST_RDX, ST_RDY, ST_SX, ST_SY, ST_FRAC:
            begin
                if (!issued_reg)
                begin
                    mul_start = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    case (state_reg)
                        ST_RDX:
                        begin
                            // floor shift of the product keeps the arithmetic shift bits
                            rdx_next = {{(RD_W-DIR_W){dir_x_reg[DIR_W-1]}}, dir_x_reg}
                                     + mul_p[RD_W+FRAC_BITS-1:FRAC_BITS];
                            state_next = ST_RDY;
                        end
                        ST_RDY:
                        begin
                            rdy_next = {{(RD_W-DIR_W){dir_y_reg[DIR_W-1]}}, dir_y_reg}
                                     + mul_p[RD_W+FRAC_BITS-1:FRAC_BITS];
                            state_next = ST_DX;
                        end
                        ST_SX:
                        begin
                            sx_next = mul_p[SD_W+FRAC_BITS-1:FRAC_BITS];
                            state_next = ST_SY;
                        end
                        ST_SY:
                        begin
                            sy_next = mul_p[SD_W+FRAC_BITS-1:FRAC_BITS];
                            mx_next = {{(MC_W-(POS_W-FRAC_BITS)){1'b0}},
                                       pos_x_reg[POS_W-1:FRAC_BITS]};
                            my_next = {{(MC_W-(POS_W-FRAC_BITS)){1'b0}},
                                       pos_y_reg[POS_W-1:FRAC_BITS]};
                            n_next = '0;
                            side_next = 1'b0;
                            left_next = 1'b0;
                            state_next = ST_STEP;
                        end
                        default:
                        begin
                            // only the low fraction bits of position plus offset matter
                            frac_next = (side_reg ? pos_x_reg[WFRAC_W-1:0]
                                                  : pos_y_reg[WFRAC_W-1:0])
                                      + mul_p[FRAC_BITS+WFRAC_W-1:FRAC_BITS];
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                if (step_x)
                begin
                    sx_next = sx_reg + {{(SD_W-DIST_W){1'b0}}, dx_reg};
                end
                else
                begin
                    sy_next = sy_reg + {{(SD_W-DIST_W){1'b0}}, dy_reg};
                end
                mx_next = mx_step;
                my_next = my_step;
                side_next = !step_x;
                n_next = n_reg + 1'b1;
                ram_raddr = my_step[AW-1:0];
                if (off_map)
                begin
                    left_next = 1'b1;
                    state_next = ST_PERP;
                end
                else
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (ram_rdata[mx_reg[AW-1:0]])
                begin
                    state_next = ST_PERP;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_PERP:
            begin
                perp_next = side_reg ? sy_reg - {{(SD_W-DIST_W){1'b0}}, dy_reg}
                                     : sx_reg - {{(SD_W-DIST_W){1'b0}}, dx_reg};
                issued_next = 1'b0;
                if (perp_next == '0)
                begin
                    lh_next = HEIGHT_MAX;
                    state_next = ST_FRAC;
                end
                else
                begin
                    state_next = ST_LH;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    o_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (o_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            issued_reg <= 1'b0;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            pos_x_reg <= POS_W'(2129920);
            pos_y_reg <= POS_W'(2129920);
            dir_x_reg <= -DIR_W'(65536);
            dir_y_reg <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= DIR_W'(43253);
            width_reg <= SW_W'(640);
        end
        else
        begin
            state_reg <= state_next;
            issued_reg <= issued_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POS_X:    pos_x_reg <= cfg_data[POS_W-1:0];
                    CFG_POS_Y:    pos_y_reg <= cfg_data[POS_W-1:0];
                    CFG_DIR_X:    dir_x_reg <= cfg_data[DIR_W-1:0];
                    CFG_DIR_Y:    dir_y_reg <= cfg_data[DIR_W-1:0];
                    CFG_PLANE_X:  plane_x_reg <= cfg_data[DIR_W-1:0];
                    CFG_PLANE_Y:  plane_y_reg <= cfg_data[DIR_W-1:0];
                    CFG_SCREEN_W: width_reg <= cfg_data[SW_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        column_reg <= column_next;
        wr_row_reg <= wr_row_next;
        wr_col_reg <= wr_col_next;
        wr_wall_reg <= wr_wall_next;
        cam_reg <= cam_next;
        rdx_reg <= rdx_next;
        rdy_reg <= rdy_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
        side_reg <= side_next;
        left_reg <= left_next;
        n_reg <= n_next;
        perp_reg <= perp_next;
        lh_reg <= lh_next;
        frac_reg <= frac_next;
        if (o_load)
        begin
            o_side_reg <= side_reg;
            o_cx_reg <= mx_reg[CELL_W-1:0];
            o_cy_reg <= my_reg[CELL_W-1:0];
            o_perp_reg <= (perp_reg > SD_W'(DIST_MAX)) ? DIST_MAX : perp_reg[DIST_W-1:0];
            o_lh_reg <= lh_reg;
            o_start_reg <= start_val;
            o_end_reg <= end_val;
            o_frac_reg <= frac_reg;
            o_left_reg <= left_reg;
            o_col_reg <= column_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_side = o_side_reg;
    assign hit_cell_x = o_cx_reg;
    assign hit_cell_y = o_cy_reg;
    assign perp_distance = o_perp_reg;
    assign slice_height = o_lh_reg;
    assign row_first = o_start_reg;
    assign row_last = o_end_reg;
    assign wall_fraction = o_frac_reg;
    assign left_map = o_left_reg;
    assign column_echo = o_col_reg;

endmodule

[src/grdc_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module grdc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/grdc_div.sv]
// restoring divider, one quotient bit per cycle
module grdc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [grdc_pkg::DIV_NW-1:0]    num,
    input  logic [grdc_pkg::DIV_DW-1:0]    den,
    output logic                           done,
    output logic [grdc_pkg::DIV_NW-1:0]    quo
);
    import grdc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_NW-1:0] q_reg, q_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   trial;
    logic              ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        trial = {rem_reg, q_reg[DIV_NW-1]};
        ge = trial >= {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            q_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (ge)
            begin
                rem_next = DIV_DW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = trial[DIV_DW-1:0];
            end
            q_next = {q_reg[DIV_NW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo = q_reg;

endmodule

[src/grdc_mul.sv]
// signed multiplier, one 14-bit digit of b per cycle, top digit first
module grdc_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [grdc_pkg::MUL_AW-1:0] a,
    input  logic signed [grdc_pkg::MUL_BW-1:0] b,
    output logic                               done,
    output logic signed [grdc_pkg::MUL_PW-1:0] prod
);
    import grdc_pkg::*;

    localparam int CNT_W = $clog2(MUL_ND);
    localparam int PART_W = MUL_AW + MUL_DG + 1;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic                     first_reg, first_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [MUL_AW-1:0] a_reg, a_next;
    logic [MUL_BW-1:0]        b_reg, b_next;
    logic signed [MUL_PW-1:0] acc_reg, acc_next;
    logic [MUL_DG-1:0]        digit;
    logic signed [MUL_DG:0]   digit_ext;
    logic signed [PART_W-1:0] part;
    logic signed [MUL_PW-1:0] part_ext;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        first_next = first_reg;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        digit = b_reg[MUL_BW-1 -: MUL_DG];
        // only the top digit carries the sign
        digit_ext = first_reg ? {digit[MUL_DG-1], digit} : {1'b0, digit};
        part = a_reg * digit_ext;
        part_ext = {{(MUL_PW-PART_W){part[PART_W-1]}}, part};
        if (start)
        begin
            busy_next = 1'b1;
            first_next = 1'b1;
            cnt_next = '0;
            a_next = a;
            b_next = b;
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                acc_next = part_ext;
            end
            else
            begin
                acc_next = (acc_reg <<< MUL_DG) + part_ext;
            end
            first_next = 1'b0;
            b_next = b_reg << MUL_DG;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_ND - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        a_reg <= a_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
